### sv/tick_driven_calendar_clock_unit_defines.svh
// Assertion macros shared by the calendar clock checker.
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_UNIT_DEFINES_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdcc check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TDCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdcc check failed");

`endif

### sv/tdcc_pkg.sv
// Types, constants and calendar helpers for the calendar clock.
`default_nettype none
package tdcc_pkg;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TPS_W   = 16;

  localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd1000;
  localparam logic [HOUR_W-1:0]  HOUR_RESET  = 5'd15;
  localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd30;
  localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd3;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd2026;

  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = 5'd29;

  // 25 * INV25 == 1 mod 2^16; y is a multiple of 25 iff y*INV25 mod 2^16 <= 65535/25
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_LIM = 16'd2621;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] y25;
    logic div25;
    y25   = y * INV25;
    div25 = (y25 <= DIV25_LIM);
    // with y%4==0, y%100==0 iff y%25==0; y%400==0 iff y%16==0 and y%25==0
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd31;
    endcase
    if ((m == MONTH_FEB) && is_leap(y)) begin
      len = DAY_LEAP_FEB;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

### sv/tick_driven_calendar_clock_unit.sv
// Calendar clock: tick prescaler, second-to-year carry chain and tick counters.
// One transaction per cycle while out_stall is low; a result passes through the
// input register, then the state and result register. The cycle path is the
// carry chain plus one 16x16 multiply for the Gregorian divisible-by-25 test.
// A set command clamps month, hour, minute and second; a zero day becomes 1.
`default_nettype none
module tick_driven_calendar_clock_unit
  import tdcc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [TPS_W-1:0]   cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [YEAR_W-1:0]  in_new_year,
  input  wire logic [MONTH_W-1:0] in_new_month,
  input  wire logic [DAY_W-1:0]   in_new_day,
  input  wire logic [HOUR_W-1:0]  in_new_hour,
  input  wire logic [MIN_W-1:0]   in_new_minute,
  input  wire logic [SEC_W-1:0]   in_new_second,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MONTH_W-1:0]      out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic [HOUR_W-1:0]       out_hour,
  output logic [MIN_W-1:0]        out_minute,
  output logic [SEC_W-1:0]        out_second,
  output logic                    out_second_done,
  output logic [CNT_W-1:0]        out_tick_count,
  output logic [CNT_W-1:0]        out_user_tick_count
);

  logic [TPS_W-1:0] tps_r;

  // input register
  logic               in_v_r;
  logic [1:0]         cmd_r;
  logic [YEAR_W-1:0]  ld_year_r;
  logic [MONTH_W-1:0] ld_month_r;
  logic [DAY_W-1:0]   ld_day_r;
  logic [HOUR_W-1:0]  ld_hour_r;
  logic [MIN_W-1:0]   ld_min_r;
  logic [SEC_W-1:0]   ld_sec_r;

  // clock state
  logic [TPS_W-1:0]   presc_r,    presc_nxt;
  logic [CNT_W-1:0]   total_r,    total_nxt;
  logic [CNT_W-1:0]   user_r,     user_nxt;
  logic [SEC_W-1:0]   sec_r,      sec_nxt;
  logic [MIN_W-1:0]   min_r,      min_nxt;
  logic [HOUR_W-1:0]  hour_r,     hour_nxt;
  logic [DAY_W-1:0]   day_r,      day_nxt;
  logic [MONTH_W-1:0] month_r,    month_nxt;
  logic [YEAR_W-1:0]  year_r,     year_nxt;
  logic               done_nxt;

  // result register
  logic               out_v_r;
  logic [YEAR_W-1:0]  o_year_r;
  logic [MONTH_W-1:0] o_month_r;
  logic [DAY_W-1:0]   o_day_r;
  logic [HOUR_W-1:0]  o_hour_r;
  logic [MIN_W-1:0]   o_min_r;
  logic [SEC_W-1:0]   o_sec_r;
  logic               o_done_r;
  logic [CNT_W-1:0]   o_total_r;
  logic [CNT_W-1:0]   o_user_r;

  logic               adv;
  logic [TPS_W:0]     presc_sum;
  logic               fire;
  logic [DAY_W-1:0]   cur_len;

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;

  assign presc_sum = {1'b0, presc_r} + {{TPS_W{1'b0}}, 1'b1};
  assign fire      = (presc_sum >= {1'b0, tps_r});
  assign cur_len   = month_len(year_r, month_r);

  always_comb begin
    presc_nxt = presc_r;
    total_nxt = total_r;
    user_nxt  = user_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    done_nxt  = 1'b0;
    unique case (cmd_r)
      CMD_TICK: begin
        total_nxt = total_r + {{(CNT_W-1){1'b0}}, 1'b1};
        user_nxt  = user_r + {{(CNT_W-1){1'b0}}, 1'b1};
        if (fire) begin
          presc_nxt = '0;
          done_nxt  = 1'b1;
          priority if (sec_r < SEC_MAX) begin
            sec_nxt = sec_r + {{(SEC_W-1){1'b0}}, 1'b1};
          end else if (min_r < MIN_MAX) begin
            sec_nxt = '0;
            min_nxt = min_r + {{(MIN_W-1){1'b0}}, 1'b1};
          end else if (hour_r < HOUR_MAX) begin
            sec_nxt  = '0;
            min_nxt  = '0;
            hour_nxt = hour_r + {{(HOUR_W-1){1'b0}}, 1'b1};
          end else if (day_r < cur_len) begin
            sec_nxt  = '0;
            min_nxt  = '0;
            hour_nxt = '0;
            day_nxt  = day_r + {{(DAY_W-1){1'b0}}, 1'b1};
          end else if (month_r < MONTH_MAX) begin
            sec_nxt   = '0;
            min_nxt   = '0;
            hour_nxt  = '0;
            day_nxt   = {{(DAY_W-1){1'b0}}, 1'b1};
            month_nxt = month_r + {{(MONTH_W-1){1'b0}}, 1'b1};
          end else begin
            sec_nxt   = '0;
            min_nxt   = '0;
            hour_nxt  = '0;
            day_nxt   = {{(DAY_W-1){1'b0}}, 1'b1};
            month_nxt = {{(MONTH_W-1){1'b0}}, 1'b1};
            year_nxt  = year_r + {{(YEAR_W-1){1'b0}}, 1'b1};
          end
        end else begin
          presc_nxt = presc_sum[TPS_W-1:0];
        end
      end
      CMD_SET: begin
        year_nxt = ld_year_r;
        priority if (ld_month_r == '0) begin
          month_nxt = {{(MONTH_W-1){1'b0}}, 1'b1};
        end else if (ld_month_r > MONTH_MAX) begin
          month_nxt = MONTH_MAX;
        end else begin
          month_nxt = ld_month_r;
        end
        day_nxt  = (ld_day_r == '0) ? {{(DAY_W-1){1'b0}}, 1'b1} : ld_day_r;
        hour_nxt = (ld_hour_r > HOUR_MAX) ? HOUR_MAX : ld_hour_r;
        min_nxt  = (ld_min_r > MIN_MAX) ? MIN_MAX : ld_min_r;
        sec_nxt  = (ld_sec_r > SEC_MAX) ? SEC_MAX : ld_sec_r;
      end
      CMD_CLEAR: begin
        user_nxt = '0;
      end
      default: begin
        // unused command: report state unchanged
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_wr_en) begin
      tps_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_r      <= in_cmd;
      ld_year_r  <= in_new_year;
      ld_month_r <= in_new_month;
      ld_day_r   <= in_new_day;
      ld_hour_r  <= in_new_hour;
      ld_min_r   <= in_new_minute;
      ld_sec_r   <= in_new_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
      total_r <= '0;
      user_r  <= '0;
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= HOUR_RESET;
      day_r   <= DAY_RESET;
      month_r <= MONTH_RESET;
      year_r  <= YEAR_RESET;
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
      if (in_v_r) begin
        presc_r <= presc_nxt;
        total_r <= total_nxt;
        user_r  <= user_nxt;
        sec_r   <= sec_nxt;
        min_r   <= min_nxt;
        hour_r  <= hour_nxt;
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r) begin
      o_year_r  <= year_nxt;
      o_month_r <= month_nxt;
      o_day_r   <= day_nxt;
      o_hour_r  <= hour_nxt;
      o_min_r   <= min_nxt;
      o_sec_r   <= sec_nxt;
      o_done_r  <= done_nxt;
      o_total_r <= total_nxt;
      o_user_r  <= user_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_year            = o_year_r;
  assign out_month           = o_month_r;
  assign out_day             = o_day_r;
  assign out_hour            = o_hour_r;
  assign out_minute          = o_min_r;
  assign out_second          = o_sec_r;
  assign out_second_done     = o_done_r;
  assign out_tick_count      = o_total_r;
  assign out_user_tick_count = o_user_r;

endmodule
`default_nettype wire

### sv/tdcc_checker.sv
// Port-level checks for the calendar clock, bound to the top level.
`default_nettype none
`include "tick_driven_calendar_clock_unit_defines.svh"
module tdcc_checker
  import tdcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [MONTH_W-1:0] out_month,
  input wire logic [DAY_W-1:0]   out_day,
  input wire logic [HOUR_W-1:0]  out_hour,
  input wire logic [MIN_W-1:0]   out_minute,
  input wire logic [SEC_W-1:0]   out_second,
  input wire logic [CNT_W-1:0]   out_tick_count
);

  // saturating load and carry chain keep the calendar fields in range
  `TDCC_ASSERT_IMPL(a_date_range, out_valid,
    (out_month != '0) && (out_month <= MONTH_MAX) && (out_day != '0))
  `TDCC_ASSERT_IMPL(a_time_range, out_valid,
    (out_hour <= HOUR_MAX) && (out_minute <= MIN_MAX) && (out_second <= SEC_MAX))
  `TDCC_ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid)
  `TDCC_ASSERT_NEXT(a_data_hold, out_valid && out_stall,
    $stable(out_tick_count) && $stable(out_second))

endmodule

bind tick_driven_calendar_clock_unit tdcc_checker u_tdcc_checker (.*);
`default_nettype wire
